/* src/prqs_pkg.sv */
// Package for the priority ready queue scheduler.
// Holds sizes, command and status codes, thread states and the sequencer states.
// No dependencies.
package prqs_pkg;

    localparam int MAX_THREADS = 16;
    localparam int TID_W = $clog2(MAX_THREADS);
    localparam int CNT_W = TID_W + 1;
    localparam int NQ = 4;

    typedef enum logic [2:0] {
        CMD_CREATE    = 3'd0,
        CMD_ACTIVATE  = 3'd1,
        CMD_SLEEP     = 3'd2,
        CMD_TICK      = 3'd3,
        CMD_SCHEDULE  = 3'd4,
        CMD_TERMINATE = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_BAD_STATE = 2'd1,
        STS_BAD_ID    = 2'd2,
        STS_FAIL      = 2'd3
    } sts_t;

    typedef enum logic [1:0] {
        TS_DEAD  = 2'd0,
        TS_READY = 2'd1,
        TS_RUN   = 2'd2,
        TS_WAIT  = 2'd3
    } tstate_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_TICK_RD,
        S_TICK_EVAL,
        S_TICK_SHIFT,
        S_SCHED,
        S_POP,
        S_REQUEUE,
        S_DONE
    } seq_t;

endpackage

/* src/priority_ready_queue_scheduler_top.sv */
// Priority ready queue scheduler: top level with command sequencer and stores; uses prqs_pkg.
// Schedule and a successful sleep search the queues; a dispatch then pops and requeues.
// A tick walks the sleep list newest first, counts down each unexpired entry, wakes and
// removes each expired one and moves the later entries down, then schedules. Throughput:
// one command at a time, in_stall is high until the sequencer is idle. Reset: asynchronous
// active-low; threads dead, queues empty.
module priority_ready_queue_scheduler_top
    import prqs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  command,
    input  logic [3:0]  thread_id,
    input  logic [1:0]  priority_req,
    input  logic [15:0] sleep_ticks,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [3:0]  new_id,
    output logic [3:0]  running_id,
    output logic        switched
);

    // Latched command.
    logic [2:0]        cmd_reg;
    logic [TID_W-1:0]  tid_reg;
    logic [1:0]        prq_reg;
    logic [15:0]       ticks_reg;

    // Thread tables. Priority has no reset; status and count reset via flops.
    logic [1:0]        prio_mem [MAX_THREADS];
    tstate_t           tstat_reg [MAX_THREADS];
    logic [15:0]       scount_reg [MAX_THREADS];

    // Ready queues: one memory indexed by {queue, slot}.
    logic [TID_W-1:0]  fifo_mem [NQ*MAX_THREADS];
    logic [TID_W-1:0]  fifo_rd_reg;
    logic [TID_W-1:0]  head_reg [NQ];
    logic [TID_W-1:0]  tail_reg [NQ];
    logic [CNT_W-1:0]  qcnt_reg [NQ];

    // Sleep list, ordered oldest first.
    logic [TID_W-1:0]  slist_mem [MAX_THREADS];
    logic [CNT_W-1:0]  slen_reg;
    logic [TID_W-1:0]  run_reg;
    logic [CNT_W-1:0]  nid_reg;

    seq_t              state_reg;
    seq_t              state_next;
    logic [CNT_W-1:0]  idx_reg;    // walk position plus one
    logic [CNT_W-1:0]  mv_reg;     // shift position during removal
    logic [TID_W-1:0]  sid_reg;    // sleeper under inspection
    logic [TID_W-1:0]  pick_tid_reg;
    logic [1:0]        pick_q_reg;
    logic [1:0]        sts_reg;
    logic [TID_W-1:0]  newid_reg;
    logic              sw_reg;

    // Result register, so that a waiting result does not hold the sequencer state.
    logic              ov_reg;
    logic [1:0]        res_sts_reg;
    logic [TID_W-1:0]  res_newid_reg;
    logic [TID_W-1:0]  res_run_reg;
    logic              res_sw_reg;
    logic              res_load;

    assign in_stall   = (state_reg != S_IDLE);
    assign out_valid  = ov_reg;
    assign status     = res_sts_reg;
    assign new_id     = res_newid_reg;
    assign running_id = res_run_reg;
    assign switched   = res_sw_reg;

    // The result register is free when empty or when its result leaves this cycle.
    assign res_load = (state_reg == S_DONE) && (!ov_reg || !out_stall);

    wire known_run = {1'b0, run_reg} < nid_reg;
    wire known_tid = {1'b0, tid_reg} < nid_reg;

    // Lowest eligible level for schedule.
    logic [1:0] lvl;
    logic       found;
    logic [1:0] fq;
    always_comb
    begin
        lvl = 2'd0;
        if (known_run && tstat_reg[run_reg] == TS_RUN)
            lvl = prio_mem[run_reg];
        found = 1'b0;
        fq = 2'd0;
        for (int q = 0; q < NQ; q++)
        begin
            if (qcnt_reg[q] != '0 && q >= int'(lvl))
            begin
                found = 1'b1;
                fq = q[1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_DECODE && cmd_reg == CMD_CREATE && nid_reg < CNT_W'(MAX_THREADS))
            prio_mem[nid_reg[TID_W-1:0]] <= prq_reg;
    end

    // Push of a thread onto its queue (activate, wake, requeue).
    logic             push_en;
    logic [TID_W-1:0] push_id;
    logic [1:0]       push_q;
    always_comb
    begin
        push_en = 1'b0;
        push_id = tid_reg;
        push_q  = prio_mem[tid_reg];
        case (state_reg)
            S_DECODE:
            begin
                push_id = tid_reg;
                push_q  = prio_mem[tid_reg];
                push_en = cmd_reg == CMD_ACTIVATE && known_tid &&
                          tstat_reg[tid_reg] == TS_DEAD &&
                          qcnt_reg[prio_mem[tid_reg]] < CNT_W'(MAX_THREADS);
            end
            S_TICK_EVAL:
            begin
                push_id = sid_reg;
                push_q  = prio_mem[sid_reg];
                push_en = scount_reg[sid_reg] == '0 && tstat_reg[sid_reg] != TS_READY &&
                          tstat_reg[sid_reg] != TS_RUN && tstat_reg[sid_reg] != TS_WAIT
                          ? qcnt_reg[prio_mem[sid_reg]] < CNT_W'(MAX_THREADS)
                          : (scount_reg[sid_reg] == '0 &&
                             qcnt_reg[prio_mem[sid_reg]] < CNT_W'(MAX_THREADS));
            end
            S_REQUEUE:
            begin
                push_id = run_reg;
                push_q  = prio_mem[run_reg];
                push_en = known_run && (tstat_reg[run_reg] == TS_READY ||
                          tstat_reg[run_reg] == TS_RUN) &&
                          qcnt_reg[prio_mem[run_reg]] < CNT_W'(MAX_THREADS);
            end
            default:
            begin
                push_en = 1'b0;
            end
        endcase
    end

    // The queue head is read into a register every cycle; the schedule step
    // captures the head of the chosen queue here for the pop that follows.
    always_ff @(posedge clk)
    begin
        if (push_en)
            fifo_mem[{push_q, tail_reg[push_q]}] <= push_id;
        fifo_rd_reg <= fifo_mem[{fq, head_reg[fq]}];
        if (state_reg == S_DECODE && cmd_reg == CMD_SLEEP && known_run &&
            slen_reg < CNT_W'(MAX_THREADS))
            slist_mem[slen_reg[TID_W-1:0]] <= run_reg;
        if (state_reg == S_TICK_SHIFT && mv_reg < slen_reg)
            slist_mem[mv_reg[TID_W-1:0] - 1'b1] <= slist_mem[mv_reg[TID_W-1:0]];
    end

    wire [TID_W-1:0] cur_slot = idx_reg[TID_W-1:0] - 1'b1;

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !in_stall)
                    state_next = S_DECODE;
            end
            S_DECODE:
            begin
                case (cmd_reg)
                    CMD_SLEEP:
                    begin
                        if (known_run && slen_reg < CNT_W'(MAX_THREADS))
                            state_next = S_SCHED;
                        else
                            state_next = S_DONE;
                    end
                    CMD_TICK:
                    begin
                        state_next = S_TICK_RD;
                    end
                    CMD_SCHEDULE:
                    begin
                        state_next = S_SCHED;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_TICK_RD:
            begin
                // Walk from newest to oldest; idx_reg is position plus one.
                if (idx_reg == '0)
                    state_next = S_SCHED;
                else
                    state_next = S_TICK_EVAL;
            end
            S_TICK_EVAL:
            begin
                if (scount_reg[sid_reg] == '0)
                    state_next = S_TICK_SHIFT;
                else
                    state_next = S_TICK_RD;
            end
            S_TICK_SHIFT:
            begin
                if (mv_reg >= slen_reg)
                    state_next = S_TICK_RD;
            end
            S_SCHED:
            begin
                if (found)
                    state_next = S_POP;
                else
                    state_next = S_DONE;
            end
            S_POP:
            begin
                state_next = S_REQUEUE;
            end
            S_REQUEUE:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (res_load)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_THREADS; i++)
            begin
                tstat_reg[i]  <= TS_DEAD;
                scount_reg[i] <= '0;
            end
            for (int q = 0; q < NQ; q++)
            begin
                head_reg[q] <= '0;
                tail_reg[q] <= '0;
                qcnt_reg[q] <= '0;
            end
            slen_reg      <= '0;
            run_reg       <= '0;
            nid_reg       <= '0;
            ov_reg        <= 1'b0;
            idx_reg       <= '0;
            mv_reg        <= '0;
            cmd_reg       <= '0;
            tid_reg       <= '0;
            prq_reg       <= '0;
            ticks_reg     <= '0;
            sid_reg       <= '0;
            pick_tid_reg  <= '0;
            pick_q_reg    <= '0;
            sts_reg       <= '0;
            newid_reg     <= '0;
            sw_reg        <= 1'b0;
            res_sts_reg   <= '0;
            res_newid_reg <= '0;
            res_run_reg   <= '0;
            res_sw_reg    <= 1'b0;
        end
        else
        begin
            if (res_load)
            begin
                ov_reg        <= 1'b1;
                res_sts_reg   <= sts_reg;
                res_newid_reg <= newid_reg;
                res_run_reg   <= run_reg;
                res_sw_reg    <= sw_reg;
            end
            else if (ov_reg && !out_stall)
                ov_reg <= 1'b0;
            if (push_en)
            begin
                tail_reg[push_q] <= tail_reg[push_q] + 1'b1;
                qcnt_reg[push_q] <= qcnt_reg[push_q] + 1'b1;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && !in_stall)
                    begin
                        cmd_reg   <= command;
                        tid_reg   <= thread_id;
                        prq_reg   <= priority_req;
                        ticks_reg <= sleep_ticks;
                        sts_reg   <= STS_OK;
                        newid_reg <= '0;
                        sw_reg    <= 1'b0;
                    end
                end
                S_DECODE:
                begin
                    case (cmd_reg)
                        CMD_CREATE:
                        begin
                            if (nid_reg >= CNT_W'(MAX_THREADS))
                                sts_reg <= STS_FAIL;
                            else
                            begin
                                tstat_reg[nid_reg[TID_W-1:0]]  <= TS_DEAD;
                                scount_reg[nid_reg[TID_W-1:0]] <= '0;
                                newid_reg <= nid_reg[TID_W-1:0];
                                nid_reg   <= nid_reg + 1'b1;
                            end
                        end
                        CMD_ACTIVATE:
                        begin
                            if (!known_tid)
                                sts_reg <= STS_BAD_ID;
                            else if (tstat_reg[tid_reg] != TS_DEAD)
                                sts_reg <= STS_BAD_STATE;
                            else if (!push_en)
                                sts_reg <= STS_FAIL;
                            else
                                tstat_reg[tid_reg] <= TS_READY;
                        end
                        CMD_SLEEP:
                        begin
                            if (!known_run)
                                sts_reg <= STS_BAD_ID;
                            else if (slen_reg >= CNT_W'(MAX_THREADS))
                                sts_reg <= STS_FAIL;
                            else
                            begin
                                tstat_reg[run_reg]  <= TS_WAIT;
                                scount_reg[run_reg] <= ticks_reg;
                                slen_reg <= slen_reg + 1'b1;
                            end
                        end
                        CMD_TICK:
                        begin
                            idx_reg <= slen_reg;
                        end
                        CMD_SCHEDULE:
                        begin
                            // The queues are searched in the next step.
                        end
                        CMD_TERMINATE:
                        begin
                            if (!known_tid)
                                sts_reg <= STS_BAD_ID;
                            else if (tstat_reg[tid_reg] == TS_DEAD)
                                sts_reg <= STS_BAD_STATE;
                            else
                                tstat_reg[tid_reg] <= TS_DEAD;
                        end
                        default:
                        begin
                            sts_reg <= STS_FAIL;
                        end
                    endcase
                end
                S_TICK_RD:
                begin
                    if (idx_reg != '0)
                        sid_reg <= slist_mem[cur_slot];
                end
                S_TICK_EVAL:
                begin
                    if (scount_reg[sid_reg] == '0)
                    begin
                        // Wake: push onto its queue and mark ready; if the queue is full, mark dead and fail.
                        if (push_en)
                            tstat_reg[sid_reg] <= TS_READY;
                        else
                        begin
                            tstat_reg[sid_reg] <= TS_DEAD;
                            sts_reg <= STS_FAIL;
                        end
                        mv_reg <= idx_reg;
                    end
                    else
                    begin
                        scount_reg[sid_reg] <= scount_reg[sid_reg] - 1'b1;
                        idx_reg <= idx_reg - 1'b1;
                    end
                end
                S_TICK_SHIFT:
                begin
                    // Close the gap left by the removed entry.
                    if (mv_reg < slen_reg)
                        mv_reg <= mv_reg + 1'b1;
                    else
                    begin
                        slen_reg <= slen_reg - 1'b1;
                        idx_reg  <= idx_reg - 1'b1;
                    end
                end
                S_SCHED:
                begin
                    if (found)
                        pick_q_reg <= fq;
                end
                S_POP:
                begin
                    pick_tid_reg <= fifo_rd_reg;
                    head_reg[pick_q_reg] <= head_reg[pick_q_reg] + 1'b1;
                    qcnt_reg[pick_q_reg] <= qcnt_reg[pick_q_reg] - 1'b1;
                    tstat_reg[fifo_rd_reg] <= TS_RUN;
                end
                S_REQUEUE:
                begin
                    // Preempted thread goes back; status was updated by the pop.
                    if (known_run && (tstat_reg[run_reg] == TS_READY ||
                        tstat_reg[run_reg] == TS_RUN))
                    begin
                        if (push_en)
                            tstat_reg[run_reg] <= TS_READY;
                        else
                        begin
                            tstat_reg[run_reg] <= TS_DEAD;
                            sts_reg <= STS_FAIL;
                        end
                    end
                    run_reg <= pick_tid_reg;
                    sw_reg  <= 1'b1;
                end
                default:
                begin
                    // The done step only hands the result to the result register.
                end
            endcase
        end
    end

endmodule
